### rtl/core/hffa_pkg.sv
// package: item types, codes and constants of the hemicube form factor accumulator
`default_nettype none
package hffa_pkg;

  typedef struct packed {
    logic [1:0]  func;
    logic [12:0] element_id;
    logic [7:0]  row;
    logic [7:0]  col;
    logic        face_side;
    logic [31:0] table_value;
    logic [31:0] area_ratio;
  } in_item_t;

  typedef struct packed {
    logic [12:0] element_echo;
    logic [28:0] form_factor;
    logic        overflow;
  } out_item_t;

  localparam logic [1:0] FUNC_LOAD_TOP  = 2'd0;
  localparam logic [1:0] FUNC_LOAD_SIDE = 2'd1;
  localparam logic [1:0] FUNC_PIXEL     = 2'd2;
  localparam logic [1:0] FUNC_READ      = 2'd3;

  // register index is paddr[2]
  localparam logic REG_HEMI_RES      = 1'b0;
  localparam logic REG_ELEMENT_COUNT = 1'b1;

  localparam logic [8:0]  HEMI_RES_RESET = 9'd256;
  localparam logic [28:0] Q28_ONE        = 29'd268435456;
  localparam logic [28:0] Q28_CLAMP      = 29'd268462300;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FOLD,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_RD_RD,
    ST_RD_MUL,
    ST_RD_OUT
  } state_t;

  typedef struct packed {
    logic       start;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] hc;
  } fold_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] row;
    logic [7:0] col;
  } fold_rsp_t;

endpackage
`default_nettype wire

### rtl/core/hffa_fold.sv
// fold unit: folds a pixel row and column about the face center, one remainder bit a cycle
`default_nettype none
module hffa_fold (
  input  wire                  clk,
  input  wire                  rst,
  input  hffa_pkg::fold_req_t  req,
  output hffa_pkg::fold_rsp_t  rsp
);
  import hffa_pkg::*;

  logic       busy;
  logic       done;
  logic [2:0] cnt;
  logic [7:0] hc;
  logic [7:0] orig_r;
  logic [7:0] orig_c;
  logic [7:0] sh_r;
  logic [7:0] sh_c;
  logic [7:0] rem_r;
  logic [7:0] rem_c;
  logic [7:0] rem_r_next;
  logic [7:0] rem_c_next;
  logic [8:0] trial_r;
  logic [8:0] trial_c;

  // restoring remainder step on both lanes
  always_comb begin
    trial_r = {rem_r, sh_r[7]};
    trial_c = {rem_c, sh_c[7]};
    rem_r_next = (trial_r >= {1'b0, hc}) ? 8'(trial_r - {1'b0, hc}) : trial_r[7:0];
    rem_c_next = (trial_c >= {1'b0, hc}) ? 8'(trial_c - {1'b0, hc}) : trial_c[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= busy && (cnt == 3'd7);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      hc     <= req.hc;
      orig_r <= req.row;
      orig_c <= req.col;
      sh_r   <= req.row;
      sh_c   <= req.col;
      rem_r  <= 8'd0;
      rem_c  <= 8'd0;
    end else if (busy) begin
      sh_r  <= {sh_r[6:0], 1'b0};
      sh_c  <= {sh_c[6:0], 1'b0};
      rem_r <= rem_r_next;
      rem_c <= rem_c_next;
    end
  end

  always_comb begin
    rsp.done = done;
    rsp.row  = (orig_r < hc) ? orig_r : 8'(hc - 8'd1 - rem_r);
    rsp.col  = (orig_c < hc) ? orig_c : 8'(hc - 8'd1 - rem_c);
  end

endmodule
`default_nettype wire

### rtl/core/hemicube_form_factor_accumulator.sv
// top level: hemicube delta form factor tables, per-element accumulators and readout
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | hffa_pkg::in_item_t
//   rsp     | out       | rsp_valid / rsp_ready | hffa_pkg::out_item_t
//   apb     | in/out    | psel penable pready   | paddr pwdata prdata
//
// a table load is written when accepted; a pixel with a valid element runs the 8-step fold unit,
// then the read and write-back of the accumulator memory; a readout runs read, multiply, clamp.
// after reset a clearing pass zeroes the accumulator memory with req_ready low;
// register writes are taken throughout.
// a readout waits in its last cycle while the output register still holds an unclaimed item.
`default_nettype none
module hemicube_form_factor_accumulator #(
  parameter int MAX_ELEMENTS = 4096,
  parameter int MAX_HALF_RES = 128
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  req_valid,
  output logic                 req_ready,
  input  hffa_pkg::in_item_t   req,
  output logic                 rsp_valid,
  input  wire                  rsp_ready,
  output hffa_pkg::out_item_t  rsp,
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire  [2:0]           paddr,
  input  wire  [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import hffa_pkg::*;

  localparam int EW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int TABLE_DEPTH = MAX_HALF_RES * MAX_HALF_RES;
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [EW-1:0] LAST_ELEMENT = EW'(MAX_ELEMENTS - 1);

  // configuration registers
  logic [8:0]  hemi_res;
  logic [12:0] element_count;

  // control
  state_t      state;
  state_t      state_next;
  in_item_t    item;
  logic [EW-1:0] clr_idx;
  logic        res_zero;
  logic [63:0] prod;

  // memories
  logic [31:0] acc_mem  [MAX_ELEMENTS];
  logic [31:0] top_mem  [TABLE_DEPTH];
  logic [31:0] side_mem [TABLE_DEPTH];
  logic [31:0] acc_q;
  logic [31:0] top_q;
  logic [31:0] side_q;

  logic          acc_we;
  logic [EW-1:0] acc_waddr;
  logic [31:0]   acc_wdata;
  logic [EW-1:0] acc_raddr;
  logic [AW-1:0] tab_raddr;
  logic [AW-1:0] tab_waddr;

  logic        accept;
  logic        load_ok;
  logic        id_ok;
  logic [7:0]  half;
  logic [7:0]  hc;
  logic [32:0] sum;
  logic [31:0] add_val;
  logic [47:0] scaled;
  logic        out_load;
  logic        zero_next;
  out_item_t   out_next;
  fold_req_t   fold_req;
  fold_rsp_t   fold_rsp;

  hffa_fold u_fold (
    .clk (clk),
    .rst (rst),
    .req (fold_req),
    .rsp (fold_rsp)
  );

  // register port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hemi_res      <= HEMI_RES_RESET;
      element_count <= 13'd0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_HEMI_RES) begin
        hemi_res <= pwdata[8:0];
      end else begin
        element_count <= pwdata[12:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_ELEMENT_COUNT) begin
      prdata = {19'd0, element_count};
    end else begin
      prdata = {23'd0, hemi_res};
    end
  end

  // effective half resolution, saturated to the table size
  always_comb begin
    half = hemi_res[8:1];
    hc   = (32'(half) > MAX_HALF_RES) ? 8'(MAX_HALF_RES) : half;
  end

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign load_ok   = (32'(req.row) < MAX_HALF_RES) && (32'(req.col) < MAX_HALF_RES);
  assign id_ok     = (req.element_id < element_count) && (32'(req.element_id) < MAX_ELEMENTS);
  assign tab_waddr = AW'(32'(req.row) * MAX_HALF_RES + 32'(req.col));
  assign tab_raddr = AW'(32'(fold_rsp.row) * MAX_HALF_RES + 32'(fold_rsp.col));
  assign acc_raddr = EW'(item.element_id);

  always_comb begin
    fold_req.start = accept && (req.func == FUNC_PIXEL) && id_ok && (hc != 8'd0);
    fold_req.row   = req.row;
    fold_req.col   = req.col;
    fold_req.hc    = hc;
  end

  // saturating accumulate
  always_comb begin
    add_val = item.face_side ? side_q : top_q;
    sum     = {1'b0, acc_q} + {1'b0, add_val};
  end

  // readout scaling and clamp
  always_comb begin
    scaled = prod[63:16];
    out_next.element_echo = item.element_id;
    if (res_zero) begin
      out_next.form_factor = 29'd0;
      out_next.overflow    = 1'b0;
    end else if (scaled > 48'(Q28_ONE)) begin
      out_next.form_factor = Q28_CLAMP;
      out_next.overflow    = 1'b1;
    end else begin
      out_next.form_factor = scaled[28:0];
      out_next.overflow    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    acc_we     = 1'b0;
    acc_waddr  = acc_raddr;
    acc_wdata  = 32'd0;
    out_load   = 1'b0;
    zero_next  = res_zero;
    case (state)
      ST_CLEAR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_idx;
        if (clr_idx == LAST_ELEMENT) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (req.func)
            FUNC_PIXEL: begin
              if (fold_req.start) begin
                state_next = ST_FOLD;
              end
            end
            FUNC_READ: begin
              if (id_ok) begin
                state_next = ST_RD_RD;
              end else begin
                zero_next  = 1'b1;
                state_next = ST_RD_OUT;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_FOLD: begin
        if (fold_rsp.done) begin
          state_next = ST_PIX_RD;
        end
      end
      ST_PIX_RD: state_next = ST_PIX_WR;
      ST_PIX_WR: begin
        acc_we     = 1'b1;
        acc_wdata  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        state_next = ST_IDLE;
      end
      ST_RD_RD: state_next = ST_RD_MUL;
      ST_RD_MUL: begin
        // readout clears the entry
        acc_we     = 1'b1;
        zero_next  = (acc_q == 32'd0);
        state_next = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        if (!rsp_valid || rsp_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (state == ST_CLEAR) begin
      clr_idx <= clr_idx + EW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req;
    end
    res_zero <= zero_next;
    if (state == ST_RD_MUL) begin
      prod <= 64'(acc_q) * 64'(item.area_ratio);
    end
  end

  // accumulator memory
  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    acc_q <= acc_mem[acc_raddr];
  end

  // quarter tables
  always_ff @(posedge clk) begin
    if (accept && load_ok && (req.func == FUNC_LOAD_TOP)) begin
      top_mem[tab_waddr] <= req.table_value;
    end
    top_q <= top_mem[tab_raddr];
  end

  always_ff @(posedge clk) begin
    if (accept && load_ok && (req.func == FUNC_LOAD_SIDE)) begin
      side_mem[tab_waddr] <= req.table_value;
    end
    side_q <= side_mem[tab_raddr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp <= out_next;
    end
  end

endmodule
`default_nettype wire

### rtl/core/hffa_check.sv
// port checker for the hemicube form factor accumulator, bound to the top level
`default_nettype none
module hffa_check (
  input wire                  clk,
  input wire                  rst,
  input wire                  req_ready,
  input wire                  rsp_valid,
  input wire                  rsp_ready,
  input hffa_pkg::out_item_t  rsp
);
  import hffa_pkg::*;

  // clearing pass holds off items right after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("item taken during the clearing pass");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled result item changed");

  a_clamp_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.overflow |-> rsp.form_factor == Q28_CLAMP)
    else $error("overflow without clamp value");

  a_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.overflow |-> rsp.form_factor <= Q28_ONE)
    else $error("form factor above one without overflow");

endmodule

bind hemicube_form_factor_accumulator hffa_check u_hffa_check (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
`default_nettype wire

### tb/tb_top.sv
// testbench: randomized item stream with an in-line predictor for the form factor accumulator
`timescale 1ns / 1ps
module tb_top;
  import hffa_pkg::*;

  localparam int MAX_ELEMENTS   = 4096;
  localparam int MAX_HALF_RES   = 128;
  localparam int TABLE_ENTRIES  = MAX_HALF_RES * MAX_HALF_RES;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  in_item_t    req_item = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  out_item_t   rsp_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  hemicube_form_factor_accumulator u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req_item),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // register settings, shared by the predictor and the item generator
  logic [8:0]  cfg_hemi_res = HEMI_RES_RESET;
  logic [12:0] cfg_element_count = '0;

  // predicted block state
  bit [31:0] elem_acc [MAX_ELEMENTS];
  bit [31:0] top_tab [TABLE_ENTRIES];
  bit [31:0] side_tab [TABLE_ENTRIES];

  // generator view of which table entries hold a value
  bit top_loaded [TABLE_ENTRIES];
  bit side_loaded [TABLE_ENTRIES];

  in_item_t  pending_reqs [$];
  out_item_t readout_q [$];
  int        elem_pool [6];
  bit        quiet_mode;

  int n_queued, n_accepted, n_errors, n_phases;
  int n_loads, n_pixels, n_readouts, n_clamped;
  int gap_left, stall_left, idle_cycles;

  task automatic report_mismatch(string msg);
    if (n_errors < 100)
      $display("mismatch at %0t: %s", $realtime, msg);
    n_errors++;
  endtask

  function automatic int half_res();
    int h;
    h = int'(cfg_hemi_res) >> 1;
    if (h > MAX_HALF_RES)
      h = MAX_HALF_RES;
    return h;
  endfunction

  // indices past the face centre mirror back into the quarter table
  function automatic int fold_coord(int a, int h);
    return (a < h) ? a : h - 1 - (a % h);
  endfunction

  task automatic predict_req(in_item_t it);
    int        eid, h, addr;
    bit        live;
    bit [32:0] sum;
    bit [31:0] addend;
    bit [63:0] scaled;
    out_item_t want;
    eid  = int'(it.element_id);
    live = (it.element_id < cfg_element_count) && (eid < MAX_ELEMENTS);
    case (it.func)
      FUNC_LOAD_TOP, FUNC_LOAD_SIDE: begin
        n_loads++;
        if (it.row < MAX_HALF_RES && it.col < MAX_HALF_RES) begin
          addr = int'(it.row) * MAX_HALF_RES + int'(it.col);
          if (it.func == FUNC_LOAD_TOP)
            top_tab[addr] = it.table_value;
          else
            side_tab[addr] = it.table_value;
        end
      end
      FUNC_PIXEL: begin
        n_pixels++;
        h = half_res();
        if (h != 0 && live) begin
          addr   = fold_coord(int'(it.row), h) * MAX_HALF_RES + fold_coord(int'(it.col), h);
          addend = it.face_side ? side_tab[addr] : top_tab[addr];
          sum    = {1'b0, elem_acc[eid]} + {1'b0, addend};
          elem_acc[eid] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
      end
      FUNC_READ: begin
        n_readouts++;
        want.element_echo = it.element_id;
        want.form_factor  = '0;
        want.overflow     = 1'b0;
        if (live) begin
          if (elem_acc[eid] != 0) begin
            scaled = ({32'b0, elem_acc[eid]} * {32'b0, it.area_ratio}) >> 16;
            if (scaled > Q28_ONE) begin
              want.form_factor = Q28_CLAMP;
              want.overflow    = 1'b1;
              n_clamped++;
            end else begin
              want.form_factor = scaled[28:0];
            end
          end
          elem_acc[eid] = '0;
        end
        readout_q.push_back(want);
      end
    endcase
  endtask

  task automatic check_readout(out_item_t got);
    out_item_t want;
    if (readout_q.size() == 0) begin
      report_mismatch($sformatf("readout of element %0d with none pending", got.element_echo));
      return;
    end
    want = readout_q.pop_front();
    if (got.element_echo !== want.element_echo)
      report_mismatch($sformatf("element_echo got %0d want %0d",
                                got.element_echo, want.element_echo));
    if (got.form_factor !== want.form_factor)
      report_mismatch($sformatf("element %0d form_factor got %0h want %0h",
                                want.element_echo, got.form_factor, want.form_factor));
    if (got.overflow !== want.overflow)
      report_mismatch($sformatf("element %0d overflow got %b want %b",
                                want.element_echo, got.overflow, want.overflow));
  endtask

  function automatic int pick_gap();
    int r;
    if (quiet_mode)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      gap_left  <= 0;
    end else begin
      if (req_valid && req_ready) begin
        predict_req(req_item);
        n_accepted++;
      end
      if (!req_valid || req_ready) begin
        if (gap_left != 0) begin
          gap_left  <= gap_left - 1;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          req_item  <= pending_reqs.pop_front();
          req_valid <= 1'b1;
          gap_left  <= pick_gap();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // readout monitor with random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (rsp_valid && rsp_ready)
        check_readout(rsp_item);
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        rsp_ready  <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
        if ($urandom_range(0, 2) == 0)
          stall_left <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // write one register, then read it back
  task automatic write_register(logic reg_sel, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (reg_sel == REG_HEMI_RES)
      cfg_hemi_res = value[8:0];
    else
      cfg_element_count = value[12:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== value)
      report_mismatch($sformatf("register %0d reads %0h want %0h", reg_sel, prdata, value));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || readout_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic start_phase(int hemi, int count, bit quiet);
    wait_drained();
    write_register(REG_HEMI_RES, 32'(hemi));
    write_register(REG_ELEMENT_COUNT, 32'(count));
    quiet_mode = quiet;
    n_phases++;
  endtask

  function automatic logic [31:0] rand_table_value();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return 32'hFFFF_FFFF;
      2, 3, 4: return $urandom_range(0, 1 << 26);
      default: return $urandom_range(0, 1 << 20);
    endcase
  endfunction

  function automatic logic [31:0] rand_ratio();
    case ($urandom_range(0, 7))
      0:       return $urandom();
      1:       return 32'h0001_0000;
      2:       return $urandom_range(0, 255);
      default: return $urandom_range(0, 32'h0004_0000);
    endcase
  endfunction

  function automatic int pick_id();
    if ($urandom_range(0, 99) < 85)
      return elem_pool[$urandom_range(0, 5)];
    return $urandom_range(0, 8191);
  endfunction

  task automatic push_req(in_item_t it);
    pending_reqs.push_back(it);
    n_queued++;
  endtask

  task automatic queue_load(logic [1:0] fn, int r, int c, logic [31:0] value);
    in_item_t it;
    it.func        = fn;
    it.element_id  = 13'($urandom_range(0, 8191));
    it.row         = 8'(r);
    it.col         = 8'(c);
    it.face_side   = 1'($urandom_range(0, 1));
    it.table_value = value;
    it.area_ratio  = $urandom();
    if (r < MAX_HALF_RES && c < MAX_HALF_RES) begin
      if (fn == FUNC_LOAD_TOP)
        top_loaded[r * MAX_HALF_RES + c] = 1'b1;
      else
        side_loaded[r * MAX_HALF_RES + c] = 1'b1;
    end
    push_req(it);
  endtask

  // a pixel never reaches a table entry that has not been loaded
  task automatic queue_pixel(int eid, int r, int c, bit side);
    int       h, fr, fc;
    in_item_t it;
    h = half_res();
    if (h != 0) begin
      fr = fold_coord(r, h);
      fc = fold_coord(c, h);
      if (side ? !side_loaded[fr * MAX_HALF_RES + fc] : !top_loaded[fr * MAX_HALF_RES + fc])
        queue_load(side ? FUNC_LOAD_SIDE : FUNC_LOAD_TOP, fr, fc, rand_table_value());
    end
    it.func        = FUNC_PIXEL;
    it.element_id  = 13'(eid);
    it.row         = 8'(r);
    it.col         = 8'(c);
    it.face_side   = side;
    it.table_value = $urandom();
    it.area_ratio  = $urandom();
    push_req(it);
  endtask

  task automatic queue_read(int eid, logic [31:0] ratio);
    in_item_t it;
    it.func        = FUNC_READ;
    it.element_id  = 13'(eid);
    it.row         = 8'($urandom_range(0, 255));
    it.col         = 8'($urandom_range(0, 255));
    it.face_side   = 1'($urandom_range(0, 1));
    it.table_value = $urandom();
    it.area_ratio  = ratio;
    push_req(it);
  endtask

  // pixel bursts onto a few elements, read back now and then, with stray loads
  task automatic random_phase(int n_items);
    int lim, first, r;
    lim = int'(cfg_element_count);
    if (lim > MAX_ELEMENTS)
      lim = MAX_ELEMENTS;
    foreach (elem_pool[k])
      elem_pool[k] = (lim > 0) ? $urandom_range(0, lim - 1) : $urandom_range(0, 8191);
    first = n_queued;
    while (n_queued - first < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 10)
        queue_load($urandom_range(0, 1) ? FUNC_LOAD_SIDE : FUNC_LOAD_TOP,
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 127),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 127),
                   rand_table_value());
      else if (r < 72)
        queue_pixel(pick_id(), $urandom_range(0, 255), $urandom_range(0, 255),
                    1'($urandom_range(0, 1)));
      else
        queue_read(pick_id(), rand_ratio());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    start_phase(256, 4096, 1'b0);
    queue_load(FUNC_LOAD_TOP, 0, 0, 32'hFFFF_FFFF);
    queue_load(FUNC_LOAD_SIDE, 127, 127, 32'h1000_0000);
    queue_load(FUNC_LOAD_TOP, 128, 5, $urandom());
    queue_load(FUNC_LOAD_SIDE, 3, 255, $urandom());
    queue_load(FUNC_LOAD_TOP, 127, 0, 32'h0);
    queue_pixel(0, 0, 0, 1'b0);
    queue_pixel(0, 255, 255, 1'b0);       // folds onto the same entry, sum saturates
    queue_read(0, 32'h0);
    queue_pixel(4095, 127, 127, 1'b1);
    queue_read(4095, 32'h0001_0000);      // exactly one, not clamped
    queue_pixel(4095, 128, 128, 1'b1);
    queue_read(4095, 32'h0001_0001);      // just above one
    queue_read(4095, 32'hFFFF_FFFF);      // entry was cleared by the readout
    queue_pixel(4096, 0, 0, 1'b0);
    queue_pixel(8191, 0, 0, 1'b1);
    queue_read(4096, 32'hFFFF_FFFF);
    queue_read(8191, 32'hFFFF_FFFF);
    queue_pixel(1, 200, 64, 1'b1);
    queue_pixel(1, 127, 0, 1'b0);
    queue_read(1, 32'hFFFF_FFFF);
    queue_pixel(2, 0, 0, 1'b0);
    queue_read(2, 32'h1);

    start_phase(2, 16, 1'b0);
    random_phase(120);
    start_phase(511, 4096, 1'b1);
    random_phase(150);
    start_phase(0, 8191, 1'b0);
    random_phase(60);
    start_phase(101, 0, 1'b0);
    random_phase(60);
    start_phase(1, 100, 1'b1);
    random_phase(50);
    start_phase(256, 4095, 1'b0);
    random_phase(200);
    start_phase(2 * $urandom_range(1, 128), $urandom_range(1, 4096), 1'b0);
    random_phase(200);

    wait_drained();
    $display("%0d items over %0d register settings: %0d table loads, %0d pixels",
             n_accepted, n_phases, n_loads, n_pixels);
    $display("%0d readouts checked, %0d clamped, %0d mismatches",
             n_readouts, n_clamped, n_errors);
    if (n_errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
